[rtl/pie_pkg.sv]
// shared types, codes and defaults for the positional insert/erase array
// no dependencies

package pie_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WIDTH_DEFAULT = 32;

  localparam int OPCODE_W = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_RESIZE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_ERASE  = 2'd2;
  localparam logic [1:0] CELL_FILL   = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]          element_count;
    logic [STATUS_W-1:0]       status;
  } result_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

[rtl/pie_cell.sv]
// one storage cell of the array row, shifting with its neighbors
// depends on pie_pkg

module pie_cell #(
  parameter int WIDTH = pie_pkg::WIDTH_DEFAULT,
  parameter int CW    = pie_pkg::POS_W,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  pie_pkg::cell_ctl_t  ctl,
  input  logic [CW-1:0]       count,
  input  logic [WIDTH-1:0]    value,
  input  logic [WIDTH-1:0]    left,
  input  logic [WIDTH-1:0]    right,
  output logic [WIDTH-1:0]    data
);
  import pie_pkg::*;

  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CMPW-1:0] IDX    = CMPW'(INDEX);
  localparam logic [CMPW-1:0] IDX_P1 = CMPW'(INDEX + 1);

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;

  assign pos_x = CMPW'(ctl.pos);
  assign cnt_x = CMPW'(count);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CELL_INSERT: begin
        if (IDX == pos_x) begin
          data <= value;
        end else if (IDX > pos_x && IDX <= cnt_x) begin
          data <= left;
        end
      end
      CELL_ERASE: begin
        if (IDX >= pos_x && IDX_P1 < cnt_x) begin
          data <= right;
        end
      end
      CELL_FILL: begin
        if (IDX >= cnt_x && IDX < pos_x) begin
          data <= value;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

[rtl/pie_ctrl.sv]
// operation decode, bounds checks and element count register
// depends on pie_pkg

module pie_ctrl #(
  parameter int DEPTH = pie_pkg::DEPTH_DEFAULT,
  parameter int CW    = pie_pkg::POS_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [pie_pkg::OPCODE_W-1:0]  opcode,
  input  logic [pie_pkg::POS_W-1:0]     position,
  output logic [CW-1:0]                 count,
  output logic [CW-1:0]                 count_next,
  output logic [pie_pkg::STATUS_W-1:0]  status,
  output pie_pkg::cell_ctl_t            ctl
);
  import pie_pkg::*;

  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [1:0]      cmd;

  assign pos_x = CMPW'(position);
  assign cnt_x = CMPW'(count);

  always_comb begin
    status     = ST_OK;
    cmd        = CELL_HOLD;
    count_next = count;
    unique case (opcode)
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status = ST_BADPOS;
        end else if (cnt_x >= DEPTH_X) begin
          status = ST_FULL;
        end else begin
          cmd        = CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      OP_ERASE: begin
        if (pos_x >= cnt_x) begin
          status = ST_BADPOS;
        end else begin
          cmd        = CELL_ERASE;
          count_next = count - CW'(1);
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) begin
          status = ST_BADPOS;
        end
      end
      default: begin
        if (pos_x > DEPTH_X) begin
          status = ST_FULL;
        end else begin
          cmd        = CELL_FILL;
          count_next = pos_x[CW-1:0];
        end
      end
    endcase
  end

  assign ctl.cmd = accept ? cmd : CELL_HOLD;
  assign ctl.pos = position;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(count) <= DEPTH_X)
    else $error("element count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == OP_INSERT && status == ST_OK |=> count == $past(count) + CW'(1))
    else $error("successful insert did not grow the count");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    accept && status != ST_OK |=> $stable(count))
    else $error("refused operation changed the count");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |-> ctl.cmd == CELL_HOLD)
    else $error("cells commanded without a transaction");

endmodule

[rtl/positional_insert_erase_array_core.sv]
// top level: bounded ordered array with positional insert, erase, read and resize
// depends on pie_pkg, pie_ctrl, pie_cell
//
// Each request transaction is one operation on a row of DEPTH cells: all cells shift toward
// or away from the addressed position in parallel, so a new request is taken every cycle
// while the result register is free or being drained. Every request gives exactly one result
// with the count after the operation and a status (ok, full or length beyond capacity, bad
// position). Refused operations leave the array unchanged. Reads return the element
// sign-extended from WIDTH bits, zero for every other operation. Entries beyond the count
// hold stale data and are never read.

module positional_insert_erase_array_core #(
  parameter int DEPTH = pie_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = pie_pkg::WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  pie_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output pie_pkg::result_t  result
);
  import pie_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic                accept;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [STATUS_W-1:0] status;
  cell_ctl_t           ctl;
  logic [WIDTH-1:0]    value_w;
  logic [WIDTH-1:0]    data [DEPTH];
  logic [WIDTH-1:0]    sel;
  logic [VALUE_W-1:0]  sel_ext;
  logic [VALUE_W-1:0]  read_value_next;
  logic [CMPW-1:0]     count_next_x;

  assign request_stall = result_valid && result_stall;
  assign accept        = request_valid && !request_stall;

  generate
    if (WIDTH >= VALUE_W) begin : g_wide
      assign value_w = WIDTH'(request.value);
    end else begin : g_narrow
      assign value_w = request.value[WIDTH-1:0];
    end
  endgenerate

  pie_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (request.opcode),
    .position   (request.position),
    .count      (count),
    .count_next (count_next),
    .status     (status),
    .ctl        (ctl)
  );

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] left;
      logic [WIDTH-1:0] right;
      if (i == 0) begin : g_first
        assign left = value_w;
      end else begin : g_mid_l
        assign left = data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right = data[i];
      end else begin : g_mid_r
        assign right = data[i+1];
      end
      pie_cell #(
        .WIDTH (WIDTH),
        .CW    (CW),
        .INDEX (i)
      ) u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .count (count),
        .value (value_w),
        .left  (left),
        .right (right),
        .data  (data[i])
      );
    end
  endgenerate

  always_comb begin
    sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMPW'(request.position) == CMPW'(i)) begin
        sel = sel | data[i];
      end
    end
  end

  generate
    if (WIDTH >= VALUE_W) begin : g_rd_wide
      assign sel_ext = sel[VALUE_W-1:0];
    end else begin : g_rd_narrow
      assign sel_ext = {{(VALUE_W - WIDTH){sel[WIDTH-1]}}, sel};
    end
  endgenerate

  assign read_value_next = (request.opcode == OP_READ && status == ST_OK) ? sel_ext : '0;
  assign count_next_x    = CMPW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.read_value    <= read_value_next;
      result.element_count <= count_next_x[POS_W-1:0];
      result.status        <= status;
    end
  end

endmodule
